// ----- hw/rtl/cdtc_pkg.sv -----
package cdtc_pkg;

  localparam int MAX_TRACKS_DEF     = 99;
  localparam int RESTART_FRAMES_DEF = 225;

  localparam int ADDR_W    = 19;
  localparam int NUM_W     = 7;
  localparam int CNT_W     = 8;
  localparam int DELTA_W   = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [3:0] {
    CMD_WRITE    = 4'd0,
    CMD_INSERT   = 4'd1,
    CMD_REMOVE   = 4'd2,
    CMD_PLAY     = 4'd3,
    CMD_PAUSE    = 4'd4,
    CMD_STOP     = 4'd5,
    CMD_SELECT   = 4'd6,
    CMD_NEXT     = 4'd7,
    CMD_PREVIOUS = 4'd8,
    CMD_SEEK     = 4'd9,
    CMD_POSITION = 4'd10,
    CMD_FINISHED = 4'd11
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_PLAY  = 2'd1,
    MODE_PAUSE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_SEEK   = 2'd0,
    OP_SELECT = 2'd1,
    OP_FETCH  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST   = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_LEADOUT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t               op;
    logic [CNT_W-1:0]  n;
    logic [NUM_W-1:0]  first;
    logic [NUM_W-1:0]  wanted;
    logic [ADDR_W-1:0] target;
    logic [NUM_W-1:0]  fetch_a;
    logic [NUM_W-1:0]  fetch_b;
  } sweep_ctl_t;

  typedef struct packed {
    logic              found;
    logic [NUM_W-1:0]  idx;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } sweep_t;

  localparam sweep_t SWEEP_INIT = '0;

endpackage

// ----- hw/rtl/cdtc_cell.sv -----
module cdtc_cell #(
  parameter int INDEX = 0
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [cdtc_pkg::NUM_W-1:0]  wr_entry,
  input  logic [cdtc_pkg::ADDR_W-1:0] wr_addr,
  input  cdtc_pkg::sweep_ctl_t        ctl,
  input  cdtc_pkg::sweep_t            pin,
  output cdtc_pkg::sweep_t            pout,
  output logic [cdtc_pkg::ADDR_W-1:0] start
);

  localparam logic [cdtc_pkg::NUM_W-1:0] IDX = INDEX[cdtc_pkg::NUM_W-1:0];

  logic                       active;
  logic [cdtc_pkg::NUM_W-1:0] sel_num;
  cdtc_pkg::sweep_t           pout_next;

  assign active  = {1'b0, IDX} < ctl.n;
  assign sel_num = ctl.first + IDX;

  always_comb begin
    pout_next = pin;
    case (ctl.op)
      cdtc_pkg::OP_SEEK: begin
        if (active && start <= ctl.target) begin
          pout_next.idx = IDX;
        end
      end
      cdtc_pkg::OP_SELECT: begin
        if (active && !pin.found && sel_num == ctl.wanted) begin
          pout_next.found  = 1'b1;
          pout_next.idx    = IDX;
          pout_next.addr_a = start;
        end
      end
      cdtc_pkg::OP_FETCH: begin
        if (ctl.fetch_a == IDX) begin
          pout_next.addr_a = start;
        end
        if (ctl.fetch_b == IDX) begin
          pout_next.addr_b = start;
        end
      end
      default: begin
        pout_next = pin;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_entry == IDX) begin
      start <= wr_addr;
    end
    pout <= pout_next;
  end

endmodule

// ----- hw/rtl/cdtc_chain.sv -----
module cdtc_chain #(
  parameter int MAX_TRACKS = cdtc_pkg::MAX_TRACKS_DEF
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [cdtc_pkg::NUM_W-1:0]  wr_entry,
  input  logic [cdtc_pkg::ADDR_W-1:0] wr_addr,
  input  cdtc_pkg::sweep_ctl_t        ctl,
  output cdtc_pkg::sweep_t            result,
  output logic [cdtc_pkg::ADDR_W-1:0] start0
);

  cdtc_pkg::sweep_t link [MAX_TRACKS+1];

  assign link[0] = cdtc_pkg::SWEEP_INIT;

  for (genvar i = 0; i < MAX_TRACKS; i++) begin : g_cell
    if (i == 0) begin : g_head
      cdtc_cell #(.INDEX(i)) u_cell (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .wr_addr  (wr_addr),
        .ctl      (ctl),
        .pin      (link[i]),
        .pout     (link[i+1]),
        .start    (start0)
      );
    end else begin : g_body
      cdtc_cell #(.INDEX(i)) u_cell (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .wr_addr  (wr_addr),
        .ctl      (ctl),
        .pin      (link[i]),
        .pout     (link[i+1]),
        .start    ()
      );
    end
  end

  assign result = link[MAX_TRACKS];

endmodule

// ----- hw/rtl/cd_transport_track_controller.sv -----
// Disc transport controller. One command word is taken at a time on the slave side, and one
// status word follows on the master side for each command. Write-start, insert, remove, play,
// pause and stop, and any command that finds nothing to do, go from the decode state straight
// to the emit state. Select, next and previous that act, and seek and position reports that
// act, first sweep along the row of track cells, one cell per cycle, each cell holding one start
// address; seek and position pass a clamp state for the target before the sweep.
// A new command is taken once the status word is formed, even while it still waits on
// m_tready; its own status word then waits until that one is taken. The start table has no
// reset; entries must be written before use.
// Configuration writes must be made only while no command is in progress.
module cd_transport_track_controller #(
  parameter int MAX_TRACKS     = cdtc_pkg::MAX_TRACKS_DEF,
  parameter int RESTART_FRAMES = cdtc_pkg::RESTART_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // entry_index[6:0], frame_address[25:7], wanted_track[32:26], seek_delta[64:33], zero fill
  input  logic [71:0]                    s_tdata,
  // cmd[3:0]
  input  logic [3:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // track_found[0], disc_loaded[1], play_mode[3:2], current_track[10:4],
  // current_entry[17:11], current_address[36:18], zero fill
  output logic [39:0]                    m_tdata,
  input  logic                           cfg_we,
  input  logic [cdtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdtc_pkg::ADDR_W-1:0]    cfg_data
);

  localparam int CYC_W = $clog2(MAX_TRACKS + 1);
  localparam logic [CYC_W-1:0] SWEEP_LEN = CYC_W'(MAX_TRACKS);
  localparam logic [cdtc_pkg::CNT_W-1:0] MAX_N = cdtc_pkg::CNT_W'(MAX_TRACKS);
  localparam logic [cdtc_pkg::ADDR_W:0] RESTART = 20'(RESTART_FRAMES);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_CLAMP  = 5'b00100,
    S_RUN    = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  state_t                        state;
  state_t                        after_decode;
  cdtc_pkg::cmd_t                cmd_q;
  logic [cdtc_pkg::NUM_W-1:0]    entry_q;
  logic [cdtc_pkg::ADDR_W-1:0]   addr_q;
  logic [cdtc_pkg::NUM_W-1:0]    wanted_q;
  logic signed [cdtc_pkg::DELTA_W-1:0] delta_q;

  logic [cdtc_pkg::NUM_W-1:0]    first_track_number;
  logic [cdtc_pkg::NUM_W-1:0]    track_count;
  logic [cdtc_pkg::ADDR_W-1:0]   leadout_address;

  logic                          loaded;
  cdtc_pkg::mode_t               mode;
  logic [cdtc_pkg::NUM_W-1:0]    tidx;
  logic [cdtc_pkg::ADDR_W-1:0]   pos;
  logic                          found;

  cdtc_pkg::op_t                 op_q;
  logic [cdtc_pkg::NUM_W-1:0]    fetch_a;
  logic [cdtc_pkg::NUM_W-1:0]    fetch_b;
  logic [cdtc_pkg::ADDR_W-1:0]   target;
  logic signed [33:0]            t_sum;
  logic [CYC_W-1:0]              cnt;

  logic [cdtc_pkg::CNT_W-1:0]    eff_n;
  logic [cdtc_pkg::ADDR_W-1:0]   hi;
  logic [cdtc_pkg::ADDR_W-1:0]   start0;
  logic signed [33:0]            lo_s;
  logic signed [33:0]            hi_s;
  logic signed [33:0]            t_lo;
  logic [33:0]                   t_clamp;
  logic                          next_ok;
  logic                          pos_ok;
  logic                          restart;
  logic                          wr_en;
  logic                          emit;
  logic [cdtc_pkg::NUM_W-1:0]    out_track;
  cdtc_pkg::sweep_ctl_t          ctl;
  cdtc_pkg::sweep_t              result;

  always_comb begin
    if (track_count == '0) begin
      eff_n = cdtc_pkg::CNT_W'(1);
    end else if ({1'b0, track_count} > MAX_N) begin
      eff_n = MAX_N;
    end else begin
      eff_n = {1'b0, track_count};
    end
  end

  assign hi      = (leadout_address == '0) ? '0 : leadout_address - 1'b1;
  assign lo_s    = $signed({15'd0, start0});
  assign hi_s    = $signed({15'd0, hi});
  assign t_lo    = (t_sum < lo_s) ? lo_s : t_sum;
  assign t_clamp = (t_lo > hi_s) ? hi_s : t_lo;

  assign next_ok = ({1'b0, tidx} + 8'd1) < eff_n;
  assign pos_ok  = loaded && mode == cdtc_pkg::MODE_PLAY && addr_q >= pos
                   && addr_q < leadout_address;
  assign restart = (tidx == '0) || ({1'b0, pos} >= ({1'b0, result.addr_a} + RESTART));

  always_comb begin
    case (cmd_q)
      cdtc_pkg::CMD_SELECT:   after_decode = loaded ? S_RUN : S_EMIT;
      cdtc_pkg::CMD_NEXT:     after_decode = (loaded && next_ok) ? S_RUN : S_EMIT;
      cdtc_pkg::CMD_PREVIOUS: after_decode = loaded ? S_RUN : S_EMIT;
      cdtc_pkg::CMD_SEEK:     after_decode = loaded ? S_CLAMP : S_EMIT;
      cdtc_pkg::CMD_POSITION: after_decode = pos_ok ? S_CLAMP : S_EMIT;
      default:                after_decode = S_EMIT;
    endcase
  end

  assign wr_en     = state == S_DECODE && cmd_q == cdtc_pkg::CMD_WRITE;
  assign emit      = state == S_EMIT && (!m_tvalid || m_tready);
  assign out_track = first_track_number + tidx;

  assign ctl.op      = op_q;
  assign ctl.n       = eff_n;
  assign ctl.first   = first_track_number;
  assign ctl.wanted  = wanted_q;
  assign ctl.target  = target;
  assign ctl.fetch_a = fetch_a;
  assign ctl.fetch_b = fetch_b;

  assign s_tready = state == S_IDLE;

  cdtc_chain #(.MAX_TRACKS(MAX_TRACKS)) u_chain (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_entry (entry_q),
    .wr_addr  (addr_q),
    .ctl      (ctl),
    .result   (result),
    .start0   (start0)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      first_track_number <= cdtc_pkg::NUM_W'(1);
      track_count        <= cdtc_pkg::NUM_W'(1);
      leadout_address    <= cdtc_pkg::ADDR_W'(1);
      loaded             <= 1'b0;
      mode               <= cdtc_pkg::MODE_STOP;
      tidx               <= '0;
      pos                <= '0;
      found              <= 1'b0;
      m_tvalid           <= 1'b0;
      cnt                <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cdtc_pkg::CFG_FIRST:   first_track_number <= cfg_data[cdtc_pkg::NUM_W-1:0];
          cdtc_pkg::CFG_COUNT:   track_count        <= cfg_data[cdtc_pkg::NUM_W-1:0];
          cdtc_pkg::CFG_LEADOUT: leadout_address    <= cfg_data;
          default: ;
        endcase
      end

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q    <= cdtc_pkg::cmd_t'(s_tuser);
            entry_q  <= s_tdata[6:0];
            addr_q   <= s_tdata[25:7];
            wanted_q <= s_tdata[32:26];
            delta_q  <= s_tdata[64:33];
            found    <= 1'b0;
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= after_decode;
          cnt   <= '0;
          case (cmd_q)
            cdtc_pkg::CMD_INSERT: begin
              loaded <= 1'b1;
              mode   <= cdtc_pkg::MODE_STOP;
              tidx   <= '0;
              pos    <= start0;
            end
            cdtc_pkg::CMD_REMOVE: begin
              loaded <= 1'b0;
              mode   <= cdtc_pkg::MODE_STOP;
              tidx   <= '0;
              pos    <= '0;
            end
            cdtc_pkg::CMD_PLAY: begin
              if (loaded) mode <= cdtc_pkg::MODE_PLAY;
            end
            cdtc_pkg::CMD_PAUSE: begin
              if (mode == cdtc_pkg::MODE_PLAY) mode <= cdtc_pkg::MODE_PAUSE;
            end
            cdtc_pkg::CMD_STOP, cdtc_pkg::CMD_FINISHED: begin
              if (loaded) begin
                mode <= cdtc_pkg::MODE_STOP;
                tidx <= '0;
                pos  <= start0;
              end
            end
            cdtc_pkg::CMD_SELECT: begin
              if (loaded) begin
                op_q <= cdtc_pkg::OP_SELECT;
              end
            end
            cdtc_pkg::CMD_NEXT: begin
              if (loaded && next_ok) begin
                op_q    <= cdtc_pkg::OP_FETCH;
                fetch_a <= tidx + 1'b1;
                fetch_b <= tidx;
              end
            end
            cdtc_pkg::CMD_PREVIOUS: begin
              if (loaded) begin
                op_q    <= cdtc_pkg::OP_FETCH;
                fetch_a <= tidx;
                fetch_b <= tidx - 1'b1;
              end
            end
            cdtc_pkg::CMD_SEEK: begin
              if (loaded) begin
                t_sum <= $signed({15'd0, pos}) + 34'(delta_q);
              end
            end
            cdtc_pkg::CMD_POSITION: begin
              if (pos_ok) begin
                t_sum <= $signed({15'd0, addr_q});
              end
            end
            default: ;
          endcase
        end
        S_CLAMP: begin
          op_q   <= cdtc_pkg::OP_SEEK;
          target <= t_clamp[cdtc_pkg::ADDR_W-1:0];
          state  <= S_RUN;
        end
        S_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == SWEEP_LEN) begin
            state <= S_EMIT;
            case (cmd_q)
              cdtc_pkg::CMD_SELECT: begin
                if (result.found) begin
                  found <= 1'b1;
                  tidx  <= result.idx;
                  pos   <= result.addr_a;
                end
              end
              cdtc_pkg::CMD_NEXT: begin
                tidx <= fetch_a;
                pos  <= result.addr_a;
              end
              cdtc_pkg::CMD_PREVIOUS: begin
                if (restart) begin
                  pos <= result.addr_a;
                end else begin
                  tidx <= fetch_b;
                  pos  <= result.addr_b;
                end
              end
              cdtc_pkg::CMD_SEEK, cdtc_pkg::CMD_POSITION: begin
                tidx <= result.idx;
                pos  <= target;
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (emit) begin
            m_tdata  <= {3'b000,
                         loaded ? pos : {cdtc_pkg::ADDR_W{1'b0}},
                         loaded ? tidx : {cdtc_pkg::NUM_W{1'b0}},
                         loaded ? out_track : {cdtc_pkg::NUM_W{1'b0}},
                         mode, loaded, found};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/cdtc_checker.sv -----
module cdtc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // one command in flight: take no word right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("command word taken while previous one in progress");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled status word changed or dropped");

  a_no_disc_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[1]) |-> (m_tdata[36:2] == 35'd0))
    else $error("status without disc shows track, position or mode");

  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:2] != 2'b11))
    else $error("play mode holds an unused code");

endmodule

bind cd_transport_track_controller cdtc_checker u_cdtc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- verif/cd_transport_track_controller_tb.sv -----
`timescale 1ns / 1ps

module cd_transport_track_controller_tb;

  localparam int TRACK_SLOTS = cdtc_pkg::MAX_TRACKS_DEF;
  localparam int RESTART = cdtc_pkg::RESTART_FRAMES_DEF;
  localparam int ADDR_TOP = 524287;
  localparam int QUIET_LIMIT = 5000;

  typedef struct packed {
    logic [31:0] delta;
    logic [6:0]  wanted;
    logic [18:0] addr;
    logic [6:0]  entry;
    logic [3:0]  cmd;
  } transport_cmd_t;

  typedef struct packed {
    logic [18:0] address;
    logic [6:0]  entry;
    logic [6:0]  track;
    logic [1:0]  mode;
    logic        loaded;
    logic        found;
  } transport_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic [3:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [cdtc_pkg::CFG_IDX_W-1:0] cfg_index = cdtc_pkg::CFG_FIRST;
  logic [cdtc_pkg::ADDR_W-1:0] cfg_data = '0;

  // transport state as the block should hold it
  logic [18:0]       start_addr [TRACK_SLOTS];
  logic              disc_in = 1'b0;
  cdtc_pkg::mode_t   play_state = cdtc_pkg::MODE_STOP;
  logic [6:0]        cur_entry = '0;
  logic [18:0]       cur_pos = '0;
  logic [6:0]        first_no = 7'd1;
  logic [6:0]        count_reg = 7'd1;
  logic [18:0]       leadout_reg = 19'd1;

  transport_cmd_t    cmd_backlog[$];
  transport_status_t status_due[$];
  transport_cmd_t    cur_word;
  int words_queued = 0;
  int words_taken = 0;
  int results_seen = 0;
  int errors = 0;
  int quiet = 0;
  int tx_idle_pct = 16;
  int rx_idle_pct = 86;

  cd_transport_track_controller dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int live_count();
    if (count_reg == 7'd0) return 1;
    if (count_reg > TRACK_SLOTS) return TRACK_SLOTS;
    return count_reg;
  endfunction

  function automatic void go_entry(int idx);
    cur_entry = 7'(idx);
    cur_pos = start_addr[idx];
  endfunction

  function automatic void seek_by(longint delta);
    longint t;
    longint lo;
    longint hi;
    int hit;
    t = longint'(cur_pos) + delta;
    lo = longint'(start_addr[0]);
    hi = longint'(leadout_reg == 19'd0 ? 19'd1 : leadout_reg) - 1;
    if (t < lo) t = lo;
    if (t > hi) t = hi;
    if (t < 0) t = 0;
    hit = 0;
    for (int i = 0; i < live_count(); i++)
      if (longint'(start_addr[i]) <= t) hit = i;
    cur_entry = 7'(hit);
    cur_pos = t[18:0];
  endfunction

  function automatic transport_status_t apply_command(transport_cmd_t w);
    transport_status_t r;
    longint el;
    int n;
    r = '0;
    n = live_count();
    case (w.cmd)
      cdtc_pkg::CMD_WRITE: if (w.entry < TRACK_SLOTS) start_addr[w.entry] = w.addr;
      cdtc_pkg::CMD_INSERT: begin
        disc_in = 1'b1;
        play_state = cdtc_pkg::MODE_STOP;
        go_entry(0);
      end
      cdtc_pkg::CMD_REMOVE: begin
        disc_in = 1'b0;
        play_state = cdtc_pkg::MODE_STOP;
        cur_entry = '0;
        cur_pos = '0;
      end
      cdtc_pkg::CMD_PLAY: if (disc_in) play_state = cdtc_pkg::MODE_PLAY;
      cdtc_pkg::CMD_PAUSE:
        if (play_state == cdtc_pkg::MODE_PLAY) play_state = cdtc_pkg::MODE_PAUSE;
      cdtc_pkg::CMD_STOP, cdtc_pkg::CMD_FINISHED: if (disc_in) begin
        play_state = cdtc_pkg::MODE_STOP;
        go_entry(0);
      end
      cdtc_pkg::CMD_SELECT: if (disc_in) begin
        for (int i = 0; i < n; i++) begin
          if (!r.found && 7'(first_no + i) == w.wanted) begin
            go_entry(i);
            r.found = 1'b1;
          end
        end
      end
      cdtc_pkg::CMD_NEXT: if (disc_in && cur_entry + 1 < n) go_entry(cur_entry + 1);
      cdtc_pkg::CMD_PREVIOUS: if (disc_in) begin
        el = longint'(cur_pos) - longint'(start_addr[cur_entry]);
        if (cur_entry == 7'd0 || el >= RESTART) go_entry(cur_entry);
        else go_entry(cur_entry - 1);
      end
      cdtc_pkg::CMD_SEEK: if (disc_in) seek_by(longint'($signed(w.delta)));
      cdtc_pkg::CMD_POSITION: begin
        if (disc_in && play_state == cdtc_pkg::MODE_PLAY && w.addr >= cur_pos &&
            w.addr < leadout_reg)
          seek_by(longint'(w.addr) - longint'(cur_pos));
      end
      default: ;
    endcase
    r.loaded = disc_in;
    r.mode = play_state;
    r.track = disc_in ? 7'(first_no + cur_entry) : 7'd0;
    r.entry = disc_in ? cur_entry : 7'd0;
    r.address = disc_in ? cur_pos : 19'd0;
    return r;
  endfunction

  always @(posedge clk) begin : drive_cmd
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        status_due.insert(status_due.size(), apply_command(cur_word));
        words_taken++;
        tx_idle_pct <= words_taken < 560 ? 16 : words_taken < 1120 ? 86 : 0;
        rx_idle_pct <= words_taken < 560 ? 86 : words_taken < 1120 ? 16 : 0;
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur_word = cmd_backlog.pop_front();
          s_tdata <= {7'd0, cur_word.delta, cur_word.wanted, cur_word.addr, cur_word.entry};
          s_tuser <= cur_word.cmd;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch_status
    transport_status_t seen;
    transport_status_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen = m_tdata[36:0];
      results_seen++;
      if (status_due.size() == 0) begin
        $error("status word with none expected");
        errors++;
      end else begin
        want = status_due.pop_front();
        check_field("track_found", want.found, seen.found);
        check_field("disc_loaded", want.loaded, seen.loaded);
        check_field("play_mode", want.mode, seen.mode);
        check_field("current_track", want.track, seen.track);
        check_field("current_entry", want.entry, seen.entry);
        check_field("current_address", want.address, seen.address);
      end
    end
    m_tready <= $urandom_range(0, 99) >= rx_idle_pct;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic transport_cmd_t mk(logic [3:0] c, int e, int a, int wt, logic [31:0] d);
    transport_cmd_t w;
    w.cmd = c;
    w.entry = 7'(e);
    w.addr = 19'(a);
    w.wanted = 7'(wt);
    w.delta = d;
    return w;
  endfunction

  task automatic send(transport_cmd_t w);
    cmd_backlog.insert(cmd_backlog.size(), w);
    words_queued++;
    wait (words_taken == words_queued);
  endtask

  task automatic settle();
    wait (results_seen == words_taken);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cdtc_pkg::cfg_reg_t idx, logic [18:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      cdtc_pkg::CFG_FIRST: first_no = val[6:0];
      cdtc_pkg::CFG_COUNT: count_reg = val[6:0];
      cdtc_pkg::CFG_LEADOUT: leadout_reg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic transport_cmd_t next_command();
    transport_cmd_t w;
    int n;
    int k;
    n = live_count();
    w = mk(cdtc_pkg::CMD_WRITE, $urandom_range(0, 127), $urandom_range(0, ADDR_TOP),
           $urandom_range(0, 127), $urandom());
    k = $urandom_range(0, 99);
    if (!disc_in && k < 60) begin
      w.cmd = cdtc_pkg::CMD_INSERT;
    end else if (disc_in && play_state != cdtc_pkg::MODE_PLAY && k < 30) begin
      w.cmd = cdtc_pkg::CMD_PLAY;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 4) begin
        w.cmd = cdtc_pkg::CMD_WRITE;
        if ($urandom_range(0, 2) != 0) w.entry = 7'($urandom_range(0, n - 1));
      end else if (k < 8) w.cmd = cdtc_pkg::CMD_INSERT;
      else if (k < 11) w.cmd = cdtc_pkg::CMD_REMOVE;
      else if (k < 17) w.cmd = cdtc_pkg::CMD_PLAY;
      else if (k < 23) w.cmd = cdtc_pkg::CMD_PAUSE;
      else if (k < 27) w.cmd = cdtc_pkg::CMD_STOP;
      else if (k < 30) w.cmd = cdtc_pkg::CMD_FINISHED;
      else if (k < 40) begin
        w.cmd = cdtc_pkg::CMD_SELECT;
        if ($urandom_range(0, 9) < 7) w.wanted = 7'(first_no + $urandom_range(0, n));
      end else if (k < 50) w.cmd = cdtc_pkg::CMD_NEXT;
      else if (k < 62) w.cmd = cdtc_pkg::CMD_PREVIOUS;
      else if (k < 77) begin
        w.cmd = cdtc_pkg::CMD_SEEK;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: w.delta = 32'($urandom_range(0, 1200)) - 32'd600;
          4, 5: begin
            w.delta = 32'($urandom_range(RESTART - 10, RESTART + 10));
            if ($urandom_range(0, 1) != 0) w.delta = -w.delta;
          end
          6: ;
          7: w.delta = 32'h8000_0000;
          8: w.delta = 32'h7FFF_FFFF;
          default: w.delta = 32'($urandom_range(0, 400000)) - 32'd200000;
        endcase
      end else if (k < 97) begin
        w.cmd = cdtc_pkg::CMD_POSITION;
        case ($urandom_range(0, 19))
          13, 14: w.addr = cur_pos;
          15: w.addr = cur_pos - 19'd1;
          16: w.addr = leadout_reg - 19'd1;
          17: w.addr = leadout_reg;
          18, 19: ;
          default: w.addr = 19'(cur_pos + $urandom_range(0, 300));
        endcase
      end else begin
        w.cmd = 4'($urandom_range(12, 15));
      end
    end
    return w;
  endfunction

  initial begin : stimulus
    logic [18:0] plan [TRACK_SLOTS];
    int n;
    int a;
    int k;
    int v;
    int steps;
    int random_items;
    int phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send(mk(cdtc_pkg::CMD_PLAY, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_SEEK, 0, 0, 0, 32'h7FFF_FFFF));
    send(mk(cdtc_pkg::CMD_WRITE, 127, ADDR_TOP, 127, 0));
    send(mk(cdtc_pkg::CMD_WRITE, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_INSERT, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_POSITION, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_PLAY, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_POSITION, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_SEEK, 0, 0, 0, 32'h8000_0000));
    send(mk(cdtc_pkg::CMD_PAUSE, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_PAUSE, 0, 0, 0, 0));
    send(mk(4'd15, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_SELECT, 0, 0, 1, 0));
    send(mk(cdtc_pkg::CMD_REMOVE, 0, 0, 0, 0));
    settle();
    cfg_write(cdtc_pkg::CFG_FIRST, 19'd127);
    cfg_write(cdtc_pkg::CFG_COUNT, 19'd3);
    cfg_write(cdtc_pkg::CFG_LEADOUT, 19'(ADDR_TOP));
    send(mk(cdtc_pkg::CMD_WRITE, 0, 150, 0, 0));
    send(mk(cdtc_pkg::CMD_WRITE, 1, 1000, 0, 0));
    send(mk(cdtc_pkg::CMD_WRITE, 2, ADDR_TOP, 0, 0));
    send(mk(cdtc_pkg::CMD_WRITE, 98, 5, 0, 0));
    send(mk(cdtc_pkg::CMD_INSERT, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_SELECT, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_SELECT, 0, 0, 5, 0));
    send(mk(cdtc_pkg::CMD_NEXT, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_NEXT, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_PREVIOUS, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_SEEK, 0, 0, 0, 32'd300));
    send(mk(cdtc_pkg::CMD_PREVIOUS, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_SEEK, 0, 0, 0, 32'h7FFF_FFFF));
    send(mk(cdtc_pkg::CMD_PLAY, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_POSITION, 0, ADDR_TOP - 1, 0, 0));
    send(mk(cdtc_pkg::CMD_FINISHED, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_INSERT, 0, 0, 0, 0));
    send(mk(cdtc_pkg::CMD_STOP, 0, 0, 0, 0));

    random_items = 0;
    phase = 0;
    while (random_items < 1650) begin
      settle();
      k = $urandom_range(0, 9);
      v = k < 7 ? $urandom_range(1, 99) : k == 7 ? 0 : k == 8 ? 127 : $urandom_range(100, 126);
      if ($urandom_range(0, 7) == 0) v = v | ($urandom_range(1, 4095) << 7);
      cfg_write(cdtc_pkg::CFG_FIRST, 19'(v));
      k = $urandom_range(0, 9);
      v = phase == 0 ? 127 : k < 6 ? $urandom_range(1, 6) : k < 8 ? $urandom_range(7, 30) :
          k == 8 ? 0 : 99;
      if ($urandom_range(0, 7) == 0) v = v | ($urandom_range(1, 4095) << 7);
      cfg_write(cdtc_pkg::CFG_COUNT, 19'(v));
      n = live_count();

      // lay out the start table: mostly ascending tracks, now and then scattered
      a = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 600);
      for (int i = 0; i < n; i++) begin
        plan[i] = 19'(a);
        a += $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6000);
        if (a > ADDR_TOP) a = ADDR_TOP;
      end
      if (phase != 0 && $urandom_range(0, 5) == 0)
        for (int i = 0; i < n; i++) plan[i] = 19'($urandom_range(0, ADDR_TOP));
      if (phase == 0) plan[n - 1] = 19'(ADDR_TOP);

      k = $urandom_range(0, 9);
      v = plan[n - 1] + $urandom_range(1, 9000);
      if (v > ADDR_TOP) v = ADDR_TOP;
      if (phase == 0 || k == 8) v = ADDR_TOP;
      else if (k == 6) v = 0;
      else if (k == 7) v = 1;
      else if (k == 9) v = $urandom_range(0, ADDR_TOP);
      cfg_write(cdtc_pkg::CFG_LEADOUT, 19'(v));

      for (int i = 0; i < n; i++)
        send(mk(cdtc_pkg::CMD_WRITE, i, plan[i], $urandom_range(0, 127), $urandom()));
      random_items += n;
      if (!disc_in || $urandom_range(0, 3) != 0) send(mk(cdtc_pkg::CMD_INSERT, 0, 0, 0, 0));
      steps = $urandom_range(40, 120);
      repeat (steps) send(next_command());
      random_items += steps;
      phase++;
    end

    wait (results_seen == words_taken);
    repeat (TRACK_SLOTS + 10) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d status words never arrived", status_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
